// File: src/cil_pkg.sv
// constants and register indexes for the convolutional interleaver core
// no dependencies; imported by convolutional_interleaver_core and tb_top
package cil_pkg;

  localparam int MaxBranches  = 16;
  localparam int MaxDelayStep = 16;
  localparam int StoreDepth   = 2048;

  localparam int SymW    = 8;
  localparam int CfgW    = 5;
  localparam int CfgIdxW = 2;
  localparam int BranchW = $clog2(MaxBranches);
  localparam int CountW  = $clog2(MaxBranches + 1);
  localparam int StepW   = $clog2(MaxDelayStep + 1);
  localparam int AddrW   = $clog2(StoreDepth);
  localparam int DelayW  = $clog2((MaxBranches - 1) * MaxDelayStep + 1);

  localparam logic [CfgIdxW-1:0] RegBranchCount = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegDelayStep   = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegDirection   = CfgIdxW'(2);

  localparam logic [CfgW-1:0] ResetBranchCount = CfgW'(4);
  localparam logic [CfgW-1:0] ResetDelayStep   = CfgW'(2);

endpackage

// File: src/convolutional_interleaver_core.sv
// convolutional interleaver / deinterleaver core, one byte symbol per request
// depends on cil_pkg
//
// Takes one symbol per clock cycle, back to back, unless the output queue is full and a
// result waits behind it, and returns one symbol per request in order. Each result goes
// through the stage after the RAM read and the two-entry output queue. The branch delay
// lines share a single-port 2048 x 8 RAM that is read and written at the same address in
// the accepting cycle (read-first), which sets the rate of one symbol per cycle. There is
// no clearing pass: a fill bit per branch makes entries not yet written since reset or
// the last configuration write read as zero, so the core is ready straight after reset.
// Any configuration write to a listed register restarts the commutator at branch 0 and
// empties every branch; write configuration only while the core is idle.
module convolutional_interleaver_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cil_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [cil_pkg::CfgW-1:0]      cfg_data_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [cil_pkg::SymW-1:0]      s_axis_tdata_i,  // [7:0] in_symbol
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [cil_pkg::SymW-1:0]      m_axis_tdata_o   // [7:0] out_symbol
);
  import cil_pkg::*;

  logic [CfgW-1:0]   bc_q, bc_d, m_q, m_d;
  logic              dir_q, dir_d;
  logic              cfg_clear;
  logic [CountW-1:0] b_eff, b_eff_d;
  logic [StepW-1:0]  m_eff, m_eff_d;
  logic [DelayW-1:0] start_dly;
  logic [DelayW+StepW-1:0] start_prod;

  logic [BranchW-1:0] cur_q, cur_d;
  logic [AddrW-1:0]   base_q, base_d;
  logic [DelayW-1:0]  dly_q, dly_d;
  logic [DelayW-1:0]  pos_q [MaxBranches];
  logic [MaxBranches-1:0] full_q;
  logic [DelayW-1:0]  pos_rd, pos_nx;
  logic               pos_wrap, last_branch, has_delay;
  logic [AddrW-1:0]   addr;
  logic               acc;

  logic [SymW-1:0] mem [StoreDepth];
  logic [SymW-1:0] rdata_q;

  logic            s1_valid_q, s1_pass_q, s1_full_q;
  logic [SymW-1:0] s1_sym_q, s1_out;

  logic [SymW-1:0] fifo_q [2];
  logic            rd_ptr_q, wr_ptr_q;
  logic [1:0]      fifo_cnt_q;
  logic            push, pop;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_comb begin
    bc_d      = bc_q;
    m_d       = m_q;
    dir_d     = dir_q;
    cfg_clear = 1'b0;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegBranchCount: begin
          bc_d      = cfg_data_i;
          cfg_clear = 1'b1;
        end
        RegDelayStep: begin
          m_d       = cfg_data_i;
          cfg_clear = 1'b1;
        end
        RegDirection: begin
          dir_d     = cfg_data_i[0];
          cfg_clear = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // clamped branch count and delay step, current and after a write
  always_comb begin
    if (bc_q < CfgW'(2))                 b_eff = CountW'(2);
    else if (bc_q > CfgW'(MaxBranches))  b_eff = CountW'(MaxBranches);
    else                                 b_eff = CountW'(bc_q);
    if (bc_d < CfgW'(2))                 b_eff_d = CountW'(2);
    else if (bc_d > CfgW'(MaxBranches))  b_eff_d = CountW'(MaxBranches);
    else                                 b_eff_d = CountW'(bc_d);
    if (m_q == '0)                       m_eff = StepW'(1);
    else if (m_q > CfgW'(MaxDelayStep))  m_eff = StepW'(MaxDelayStep);
    else                                 m_eff = StepW'(m_q);
    if (m_d == '0)                       m_eff_d = StepW'(1);
    else if (m_d > CfgW'(MaxDelayStep))  m_eff_d = StepW'(MaxDelayStep);
    else                                 m_eff_d = StepW'(m_d);
  end

  // delay of branch 0 after a restart
  assign start_prod = (DelayW+StepW)'(b_eff_d - CountW'(1)) * (DelayW+StepW)'(m_eff_d);
  assign start_dly  = dir_d ? start_prod[DelayW-1:0] : '0;

  // commutator and branch pointers
  assign acc         = s_axis_tvalid_i && s_axis_tready_o;
  assign has_delay   = (dly_q != '0);
  assign pos_rd      = (pos_q[cur_q] >= dly_q) ? '0 : pos_q[cur_q];
  assign pos_wrap    = ((pos_rd + DelayW'(1)) >= dly_q);
  assign pos_nx      = pos_wrap ? '0 : pos_rd + DelayW'(1);
  assign addr        = base_q + AddrW'(pos_rd);
  assign last_branch = ({1'b0, cur_q} == (b_eff - CountW'(1)));

  always_comb begin
    cur_d  = cur_q;
    base_d = base_q;
    dly_d  = dly_q;
    if (cfg_clear) begin
      cur_d  = '0;
      base_d = '0;
      dly_d  = start_dly;
    end else if (acc) begin
      if (last_branch) begin
        cur_d  = '0;
        base_d = '0;
        dly_d  = start_dly;
      end else begin
        cur_d  = cur_q + BranchW'(1);
        base_d = base_q + AddrW'(dly_q);
        dly_d  = dir_q ? dly_q - DelayW'(m_eff) : dly_q + DelayW'(m_eff);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bc_q   <= ResetBranchCount;
      m_q    <= ResetDelayStep;
      dir_q  <= 1'b0;
      cur_q  <= '0;
      base_q <= '0;
      dly_q  <= '0;
      full_q <= '0;
      for (int i = 0; i < MaxBranches; i++) pos_q[i] <= '0;
    end else begin
      bc_q   <= bc_d;
      m_q    <= m_d;
      dir_q  <= dir_d;
      cur_q  <= cur_d;
      base_q <= base_d;
      dly_q  <= dly_d;
      if (cfg_clear) begin
        full_q <= '0;
        for (int i = 0; i < MaxBranches; i++) pos_q[i] <= '0;
      end else if (acc && has_delay) begin
        pos_q[cur_q] <= pos_nx;
        if (pos_wrap) full_q[cur_q] <= 1'b1;
      end
    end
  end

  // delay store, read-first single port
  always_ff @(posedge clk_i) begin
    if (acc && has_delay) begin
      rdata_q   <= mem[addr];
      mem[addr] <= s_axis_tdata_i;
    end
  end

  // stage after the ram read
  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_pass_q <= !has_delay;
      s1_full_q <= full_q[cur_q];
      s1_sym_q  <= s_axis_tdata_i;
    end
  end

  assign s1_out = s1_pass_q ? s1_sym_q : (s1_full_q ? rdata_q : '0);

  // two-entry output queue
  assign pop             = m_axis_tvalid_o && m_axis_tready_i;
  assign push            = s1_valid_q && ((fifo_cnt_q != 2'd2) || pop);
  assign m_axis_tvalid_o = (fifo_cnt_q != 2'd0);
  assign m_axis_tdata_o  = fifo_q[rd_ptr_q];
  assign s_axis_tready_o = !(s1_valid_q && (fifo_cnt_q == 2'd2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      rd_ptr_q   <= 1'b0;
      wr_ptr_q   <= 1'b0;
      fifo_cnt_q <= 2'd0;
    end else begin
      s1_valid_q <= acc || (s1_valid_q && !push);
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      fifo_cnt_q <= fifo_cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_ptr_q] <= s1_out;
  end

  // checks
  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_cnt_q != 2'd3)
    else $error("output queue overflow");

  a_accept_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> s1_valid_q)
    else $error("accepted request lost before output queue");

  a_cur_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, cur_q} < b_eff))
    else $error("commutator beyond branch count");

  a_branch0_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!dir_q && (cur_q == '0)) |-> (dly_q == '0))
    else $error("interleave branch zero has a delay");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && (fifo_cnt_q == 2'd2) && !m_axis_tready_i) |=> s1_valid_q)
    else $error("stalled result dropped");

endmodule

// File: bench/tb_top.sv
// testbench for convolutional_interleaver_core: directed table then random symbol phases
// keeps its own model of the branch delay lines; depends on cil_pkg and the core only
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cil_pkg::*;

  localparam logic [CfgIdxW-1:0] RegBeyondList = CfgIdxW'(3);
  localparam int RandomItems = 750;
  localparam int IdleLimit = 1000;

  typedef enum logic {RowSymbol, RowWrite} row_kind_e;

  typedef struct packed {
    row_kind_e           kind;
    logic [CfgIdxW-1:0]  idx;
    logic [SymW-1:0]     val;
    logic                typed;
    logic [SymW-1:0]     want;
  } stim_row_t;

  localparam stim_row_t DirectedRows [30] = '{
    '{RowSymbol, '0, 8'h00, 1'b1, 8'h00},
    '{RowSymbol, '0, 8'hFF, 1'b1, 8'h00},
    '{RowSymbol, '0, 8'hA5, 1'b1, 8'h00},
    '{RowSymbol, '0, 8'h5A, 1'b1, 8'h00},
    '{RowSymbol, '0, 8'h80, 1'b1, 8'h80},
    '{RowSymbol, '0, 8'h01, 1'b1, 8'h00},
    '{RowSymbol, '0, 8'h7F, 1'b1, 8'h00},
    '{RowSymbol, '0, 8'h3C, 1'b1, 8'h00},
    '{RowSymbol, '0, 8'hC3, 1'b1, 8'hC3},
    '{RowSymbol, '0, 8'h11, 1'b1, 8'hFF},
    // write beyond the register list leaves the lines untouched
    '{RowWrite, RegBeyondList, 8'h1F, 1'b0, 8'h00},
    '{RowSymbol, '0, 8'h22, 1'b1, 8'h00},
    '{RowWrite, RegDirection, 8'h01, 1'b0, 8'h00},
    '{RowSymbol, '0, 8'h44, 1'b1, 8'h00},
    '{RowSymbol, '0, 8'h55, 1'b1, 8'h00},
    '{RowSymbol, '0, 8'h66, 1'b1, 8'h00},
    '{RowSymbol, '0, 8'h77, 1'b1, 8'h77},
    // branch count and step of zero, direction from bit 0 only
    '{RowWrite, RegBranchCount, 8'h00, 1'b0, 8'h00},
    '{RowWrite, RegDelayStep, 8'h00, 1'b0, 8'h00},
    '{RowWrite, RegDirection, 8'h1E, 1'b0, 8'h00},
    '{RowSymbol, '0, 8'h01, 1'b1, 8'h01},
    '{RowSymbol, '0, 8'h02, 1'b1, 8'h00},
    '{RowSymbol, '0, 8'h03, 1'b1, 8'h03},
    '{RowSymbol, '0, 8'h04, 1'b1, 8'h02},
    // saturated branch count and step
    '{RowWrite, RegBranchCount, 8'h1F, 1'b0, 8'h00},
    '{RowWrite, RegDelayStep, 8'h1F, 1'b0, 8'h00},
    '{RowWrite, RegDirection, 8'h01, 1'b0, 8'h00},
    '{RowSymbol, '0, 8'hFE, 1'b1, 8'h00},
    '{RowSymbol, '0, 8'h00, 1'b0, 8'h00},
    '{RowSymbol, '0, 8'h3C, 1'b0, 8'h00}
  };

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CfgW-1:0]    cfg_data_i;
  logic               s_axis_tvalid_i;
  logic               s_axis_tready_o;
  logic [SymW-1:0]    s_axis_tdata_i;
  logic               m_axis_tvalid_o;
  logic               m_axis_tready_i;
  logic [SymW-1:0]    m_axis_tdata_o;

  convolutional_interleaver_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  logic [CfgW-1:0]  p_branches;
  logic [CfgW-1:0]  p_step;
  logic             p_dir;
  logic [SymW-1:0]  line_mem [StoreDepth];
  int unsigned      branch_ptr [MaxBranches];
  int unsigned      commutator_at;

  logic [SymW-1:0]  expected_syms [$];
  logic             row_typed;
  logic [SymW-1:0]  row_want;
  logic [SymW-1:0]  want_sym;
  int               errors = 0;
  int               idle_cycles = 0;
  bit               quiet_tx = 1'b0;
  bit               quiet_rx = 1'b0;
  int               rx_hold = 0;

  function automatic void clear_lines();
    foreach (line_mem[k]) line_mem[k] = '0;
    foreach (branch_ptr[k]) branch_ptr[k] = 0;
    commutator_at = 0;
  endfunction

  function automatic void apply_write(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
    case (idx)
      RegBranchCount: p_branches = data;
      RegDelayStep:   p_step = data;
      RegDirection:   p_dir = data[0];
      default:        return;
    endcase
    clear_lines();
  endfunction

  function automatic int unsigned delay_of(int unsigned i, int unsigned nb, int unsigned step);
    return p_dir ? (nb - 1 - i) * step : i * step;
  endfunction

  function automatic logic [SymW-1:0] interleave_symbol(logic [SymW-1:0] sym);
    int unsigned nb, step, cur, base, d, pos, addr;
    logic [SymW-1:0] res;
    nb = p_branches;
    if (nb < 2) nb = 2;
    if (nb > MaxBranches) nb = MaxBranches;
    step = p_step;
    if (step < 1) step = 1;
    if (step > MaxDelayStep) step = MaxDelayStep;
    cur = commutator_at;
    if (cur >= nb) cur = 0;
    base = 0;
    for (int unsigned i = 0; i < cur; i++) base += delay_of(i, nb, step);
    d = delay_of(cur, nb, step);
    res = sym;
    if (d != 0) begin
      pos = branch_ptr[cur];
      if (pos >= d) pos = 0;
      addr = (base + pos) % StoreDepth;
      res = line_mem[addr];
      line_mem[addr] = sym;
      pos++;
      if (pos >= d) pos = 0;
      branch_ptr[cur] = pos;
    end
    cur++;
    if (cur >= nb) cur = 0;
    commutator_at = cur;
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [CfgW-1:0] pick_setting(int lo, int hi, int cap);
    case ($urandom_range(0, 9))
      0:       return CfgW'($urandom_range(cap + 1, 31));
      1:       return CfgW'($urandom_range(0, 1));
      2:       return CfgW'(cap);
      default: return CfgW'($urandom_range(lo, hi));
    endcase
  endfunction

  // output check, prediction and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (expected_syms.size() == 0) begin
          $error("out_symbol: expected none, got %02h", m_axis_tdata_o);
          errors++;
        end else begin
          want_sym = expected_syms.pop_front();
          if (m_axis_tdata_o !== want_sym) begin
            $error("out_symbol: expected %02h, got %02h", want_sym, m_axis_tdata_o);
            errors++;
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        want_sym = interleave_symbol(s_axis_tdata_i);
        expected_syms.push_back(row_typed ? row_want : want_sym);
      end
      if (cfg_valid_i && cfg_ready_o) apply_write(cfg_index_i, cfg_data_i);
      if ((m_axis_tvalid_o && m_axis_tready_i) || (s_axis_tvalid_i && s_axis_tready_o) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else if (++idle_cycles >= IdleLimit) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  // result side stalls
  always @(negedge clk_i) begin
    if (rx_hold > 0) begin
      m_axis_tready_i <= 1'b0;
      rx_hold = rx_hold - 1;
    end else begin
      m_axis_tready_i <= 1'b1;
      if (!quiet_rx) rx_hold = pick_gap();
    end
  end

  task automatic push_symbol(input logic [SymW-1:0] sym, input logic typed,
                             input logic [SymW-1:0] want);
    int gap;
    gap = quiet_tx ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= sym;
    row_typed       <= typed;
    row_want        <= want;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (expected_syms.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    drain();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int sent, len, phase;
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = '0;
    cfg_data_i      = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    m_axis_tready_i = 1'b0;
    row_typed       = 1'b0;
    row_want        = '0;
    p_branches      = ResetBranchCount;
    p_step          = ResetDelayStep;
    p_dir           = 1'b0;
    clear_lines();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (DirectedRows[r]) begin
      if (DirectedRows[r].kind == RowWrite) begin
        write_reg(DirectedRows[r].idx, CfgW'(DirectedRows[r].val));
      end else begin
        push_symbol(DirectedRows[r].val, DirectedRows[r].typed, DirectedRows[r].want);
      end
    end

    sent = 0;
    phase = 0;
    while (sent < RandomItems) begin
      quiet_tx = ($urandom_range(0, 4) == 0);
      quiet_rx = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 2) != 0) write_reg(RegBranchCount, pick_setting(2, 6, MaxBranches));
      if ($urandom_range(0, 2) != 0) write_reg(RegDelayStep, pick_setting(1, 4, MaxDelayStep));
      if ($urandom_range(0, 3) == 0) write_reg(RegDirection, CfgW'($urandom));
      if ($urandom_range(0, 9) == 0) write_reg(RegBeyondList, CfgW'($urandom));
      len = $urandom_range(30, 120);
      for (int k = 0; k < len; k++) begin
        // halfway through the second phase, the sender holds off until the core has emptied
        if (phase == 1 && k == len / 2) drain();
        push_symbol(SymW'($urandom), 1'b0, '0);
      end
      sent += len;
      phase++;
    end

    quiet_rx = 1'b0;
    drain();
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
src/cil_pkg.sv
src/convolutional_interleaver_core.sv
bench/tb_top.sv
